FILE: hw/rtl/fbpa_pkg.sv
// Package of types and constants shared by the fixed block pool allocator files.
`timescale 1ns / 1ps

package fbpa_pkg;

   // Field widths fixed by the interface
   localparam int ADDR_W   = 32;
   localparam int COUNT_W  = 9;
   localparam int SIZE_W   = 8;
   localparam int INDEX_W  = 8;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 2;

   // Smallest pool that a rebuild accepts
   localparam int MIN_BLOCKS = 2;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REBUILD = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_COUNT = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SIZE  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd5;
   localparam logic [STATUS_W-1:0] STATUS_NOT_READY = 3'd6;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE  = 2'd2;

   // Sequencer states
   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_EXEC,
      STATE_REM,
      STATE_LINK
   } state_type;

   // Status from the alignment check unit
   typedef struct packed {
      logic done;
      logic zero;
   } rem_status_type;

endpackage

FILE: hw/rtl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: sequencer, pool state and link memory.
//
//  channel | ports                                        | direction | transfer when
//  req     | req_valid req_stall req_mode req_free_index  | in        | valid && !stall
//  rsp     | rsp_valid rsp_stall rsp_status rsp_block_*   | out       | valid && !stall
//          | rsp_free_count                               |           |
//  csr     | csr_valid csr_ready csr_index csr_data       | in        | valid && ready
//
// Allocate, free and the unused mode pass through accept (link read issued) and
// the execution state, where allocate does the multiply-add for the block address.
// Rebuild ends in the execution state with a zero base, in the remainder state
// (alignment test) when a later check fails, else it links one entry a cycle.
// Reset is synchronous; no pool exists after reset. A request is accepted only
// while the sequencer is idle and the response register is empty or being drained.
`timescale 1ns / 1ps

module fixed_block_pool_allocator #(
   parameter int MAX_BLOCKS    = 256,
   parameter int POINTER_BYTES = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [fbpa_pkg::MODE_W-1:0]        req_mode,
   input  logic [fbpa_pkg::INDEX_W-1:0]       req_free_index,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [fbpa_pkg::STATUS_W-1:0]      rsp_status,
   output logic [fbpa_pkg::INDEX_W-1:0]       rsp_block_index,
   output logic [fbpa_pkg::ADDR_W-1:0]        rsp_block_address,
   output logic [fbpa_pkg::COUNT_W-1:0]       rsp_free_count,
   // configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]        csr_data
);

   localparam int LINK_W = $clog2(MAX_BLOCKS);
   localparam int PROD_W = LINK_W + fbpa_pkg::SIZE_W;

   // Sequencer and pool state
   fbpa_pkg::state_type state_ff, state_in;
   logic [fbpa_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [fbpa_pkg::INDEX_W-1:0]  index_ff, index_in;
   logic [LINK_W-1:0]             head_ff, head_in;
   logic [LINK_W-1:0]             cnt_ff, cnt_in;
   logic [fbpa_pkg::COUNT_W-1:0]  free_blocks_ff, free_blocks_in;
   logic [fbpa_pkg::COUNT_W-1:0]  pool_blocks_ff, pool_blocks_in;
   logic                          ready_ff, ready_in;
   logic [fbpa_pkg::ADDR_W-1:0]   pool_base_ff, pool_base_in;
   logic [fbpa_pkg::SIZE_W-1:0]   pool_size_ff, pool_size_in;

   // Configuration registers
   logic [fbpa_pkg::ADDR_W-1:0]   base_cfg_ff;
   logic [fbpa_pkg::COUNT_W-1:0]  count_cfg_ff;
   logic [fbpa_pkg::SIZE_W-1:0]   size_cfg_ff;

   // Response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [fbpa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [fbpa_pkg::INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [fbpa_pkg::ADDR_W-1:0]   rsp_address_ff, rsp_address_in;
   logic [fbpa_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // Link memory ports
   logic              wr_en;
   logic [LINK_W-1:0] wr_addr;
   logic [LINK_W-1:0] wr_data;
   logic              rd_en;
   logic [LINK_W-1:0] rd_data;

   // Remainder unit
   logic                     rem_start;
   fbpa_pkg::rem_status_type rem_status;

   logic              accept;
   logic              post;
   logic              link_last;
   logic [PROD_W-1:0] offset;
   logic              count_bad;
   logic              size_bad;
   logic              free_bad;

   // Handshakes
   assign accept    = req_valid && !req_stall;
   assign req_stall = !((state_ff == fbpa_pkg::STATE_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign csr_ready = 1'b1;

   // Checks and address arithmetic
   assign count_bad = (count_cfg_ff < fbpa_pkg::COUNT_W'(fbpa_pkg::MIN_BLOCKS))
                      || (32'(count_cfg_ff) > 32'(MAX_BLOCKS));
   assign size_bad  = (32'(size_cfg_ff) < 32'(POINTER_BYTES));
   assign free_bad  = (fbpa_pkg::COUNT_W'(index_ff) >= pool_blocks_ff)
                      || (32'(index_ff) >= 32'(MAX_BLOCKS));
   assign offset    = PROD_W'(head_ff) * PROD_W'(pool_size_ff);
   assign link_last = (32'(cnt_ff) == (32'(count_cfg_ff) - 32'd1));

   // Next state, pool updates and memory controls
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      index_in       = index_ff;
      head_in        = head_ff;
      cnt_in         = cnt_ff;
      free_blocks_in = free_blocks_ff;
      pool_blocks_in = pool_blocks_ff;
      ready_in       = ready_ff;
      pool_base_in   = pool_base_ff;
      pool_size_in   = pool_size_ff;
      post           = 1'b0;
      rsp_status_in  = fbpa_pkg::STATUS_OK;
      rsp_index_in   = '0;
      rsp_address_in = '0;
      wr_en          = 1'b0;
      wr_addr        = cnt_ff;
      wr_data        = head_ff;
      rd_en          = accept;
      rem_start      = 1'b0;

      case (state_ff)
         fbpa_pkg::STATE_IDLE: begin
            if (accept) begin
               mode_in  = req_mode;
               index_in = req_free_index;
               state_in = fbpa_pkg::STATE_EXEC;
            end
         end

         fbpa_pkg::STATE_EXEC: begin
            case (mode_ff)
               fbpa_pkg::MODE_REBUILD: begin
                  if (base_cfg_ff == '0) begin
                     post          = 1'b1;
                     rsp_status_in = fbpa_pkg::STATUS_BAD_ADDR;
                  end else begin
                     rem_start = 1'b1;
                     state_in  = fbpa_pkg::STATE_REM;
                  end
               end
               fbpa_pkg::MODE_ALLOC: begin
                  post = 1'b1;
                  if (!ready_ff) begin
                     rsp_status_in = fbpa_pkg::STATUS_NOT_READY;
                  end else if (free_blocks_ff == '0) begin
                     rsp_status_in = fbpa_pkg::STATUS_EMPTY;
                  end else begin
                     // link read was issued at accept from the current head
                     rsp_index_in   = fbpa_pkg::INDEX_W'(head_ff);
                     rsp_address_in = pool_base_ff + fbpa_pkg::ADDR_W'(offset);
                     head_in        = rd_data;
                     free_blocks_in = free_blocks_ff - fbpa_pkg::COUNT_W'(1);
                  end
               end
               fbpa_pkg::MODE_FREE: begin
                  post = 1'b1;
                  if (!ready_ff) begin
                     rsp_status_in = fbpa_pkg::STATUS_NOT_READY;
                  end else if (free_bad) begin
                     rsp_status_in = fbpa_pkg::STATUS_BAD_ADDR;
                  end else if (free_blocks_ff >= pool_blocks_ff) begin
                     rsp_status_in = fbpa_pkg::STATUS_FULL;
                  end else begin
                     // push onto the list head
                     wr_en          = 1'b1;
                     wr_addr        = LINK_W'(index_ff);
                     wr_data        = head_ff;
                     head_in        = LINK_W'(index_ff);
                     free_blocks_in = free_blocks_ff + fbpa_pkg::COUNT_W'(1);
                  end
               end
               default: begin
                  post          = 1'b1;
                  rsp_status_in = fbpa_pkg::STATUS_BAD_ADDR;
               end
            endcase
            if (post) begin
               state_in = fbpa_pkg::STATE_IDLE;
            end
         end

         fbpa_pkg::STATE_REM: begin
            if (rem_status.done) begin
               if (!rem_status.zero) begin
                  post          = 1'b1;
                  rsp_status_in = fbpa_pkg::STATUS_BAD_ADDR;
               end else if (count_bad) begin
                  post          = 1'b1;
                  rsp_status_in = fbpa_pkg::STATUS_BAD_COUNT;
               end else if (size_bad) begin
                  post          = 1'b1;
                  rsp_status_in = fbpa_pkg::STATUS_BAD_SIZE;
               end else begin
                  cnt_in   = '0;
                  state_in = fbpa_pkg::STATE_LINK;
               end
               if (post) begin
                  state_in = fbpa_pkg::STATE_IDLE;
               end
            end
         end

         fbpa_pkg::STATE_LINK: begin
            // chain entry cnt to cnt+1, the last entry to zero
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = link_last ? '0 : (cnt_ff + LINK_W'(1));
            cnt_in  = cnt_ff + LINK_W'(1);
            if (link_last) begin
               head_in        = '0;
               free_blocks_in = count_cfg_ff;
               pool_blocks_in = count_cfg_ff;
               pool_base_in   = base_cfg_ff;
               pool_size_in   = size_cfg_ff;
               ready_in       = 1'b1;
               post           = 1'b1;
               rsp_status_in  = fbpa_pkg::STATUS_OK;
               state_in       = fbpa_pkg::STATE_IDLE;
            end
         end

         default: begin
            state_in = fbpa_pkg::STATE_IDLE;
         end
      endcase

      rsp_count_in = free_blocks_in;
      if (post) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= fbpa_pkg::STATE_IDLE;
         head_ff        <= '0;
         cnt_ff         <= '0;
         free_blocks_ff <= '0;
         pool_blocks_ff <= '0;
         ready_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         cnt_ff         <= cnt_in;
         free_blocks_ff <= free_blocks_in;
         pool_blocks_ff <= pool_blocks_in;
         ready_ff       <= ready_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_cfg_ff  <= '0;
         count_cfg_ff <= fbpa_pkg::COUNT_W'(2);
         size_cfg_ff  <= fbpa_pkg::SIZE_W'(4);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            fbpa_pkg::CSR_BASE:  base_cfg_ff  <= csr_data;
            fbpa_pkg::CSR_COUNT: count_cfg_ff <= csr_data[fbpa_pkg::COUNT_W-1:0];
            fbpa_pkg::CSR_SIZE:  size_cfg_ff  <= csr_data[fbpa_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      index_ff     <= index_in;
      pool_base_ff <= pool_base_in;
      pool_size_ff <= pool_size_in;
      if (post) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_index_ff   <= rsp_index_in;
         rsp_address_ff <= rsp_address_in;
         rsp_count_ff   <= rsp_count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_index   = rsp_index_ff;
   assign rsp_block_address = rsp_address_ff;
   assign rsp_free_count    = rsp_count_ff;

   // Link memory
   fbpa_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAX_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   // Base alignment check
   fbpa_rem #(
      .WIDTH   (fbpa_pkg::ADDR_W),
      .DIVISOR (POINTER_BYTES)
   ) u_rem (
      .clock  (clock),
      .reset  (reset),
      .start  (rem_start),
      .value  (base_cfg_ff),
      .status (rem_status)
   );

   // A response appears only as the sequencer finishes an item
   a_rsp_from_sequencer: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) != fbpa_pkg::STATE_IDLE))
      else $error("response raised without an item in flight");

   // The free count never exceeds the pool size
   a_free_within_pool: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (free_blocks_ff <= pool_blocks_ff))
      else $error("free count above pool size");

   // The list head stays inside the pool while blocks are free
   a_head_in_pool: assert property (@(posedge clock) disable iff (reset)
      (ready_ff && (free_blocks_ff != '0)) |->
         (fbpa_pkg::COUNT_W'(head_ff) < pool_blocks_ff))
      else $error("free list head outside the pool");

endmodule

FILE: hw/rtl/fbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/fbpa_rem.sv
// Alignment check unit: tests a word for divisibility by a constant in one registered step.
`timescale 1ns / 1ps

module fbpa_rem #(
   parameter int WIDTH   = 32,
   parameter int DIVISOR = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [WIDTH-1:0]        value,
   output fbpa_pkg::rem_status_type status
);

   // Power-of-two part of the divisor
   function automatic int trailing_zeros(int d);
      int n;
      n = 0;
      while (((d & 1) == 0) && (n < 30)) begin
         d = d >> 1;
         n++;
      end
      return n;
   endfunction

   // Inverse of an odd factor modulo 2**WIDTH, by Newton steps
   function automatic logic [WIDTH-1:0] odd_inverse(int m);
      logic [WIDTH-1:0] mv;
      logic [WIDTH-1:0] x;
      mv = WIDTH'(m);
      x  = mv;
      for (int i = 0; i < 6; i++) begin
         x = x * (WIDTH'(2) - mv * x);
      end
      return x;
   endfunction

   localparam int               TZ       = trailing_zeros(DIVISOR);
   localparam int               ODD      = DIVISOR >> TZ;
   localparam logic [WIDTH-1:0] INV      = odd_inverse(ODD);
   localparam logic [WIDTH-1:0] LIMIT    = {WIDTH{1'b1}} / WIDTH'(ODD);
   localparam logic [WIDTH-1:0] LOW_MASK = WIDTH'((64'd1 << TZ) - 64'd1);

   logic [WIDTH-1:0] prod_ff, prod_in;
   logic             low_ok_ff, low_ok_in;
   logic             done_ff, done_in;

   // A multiple of the odd factor times its inverse lands at or below the limit
   assign prod_in   = value * INV;
   assign low_ok_in = ((value & LOW_MASK) == '0);
   assign done_in   = start;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff   <= prod_in;
         low_ok_ff <= low_ok_in;
      end
   end

   assign status.done = done_ff;
   assign status.zero = low_ok_ff && (prod_ff <= LIMIT);

endmodule
